/* hw/rtl/fraction_reduce_defines.svh */
// assertion macros used by the checker module fr_chk
`ifndef FRACTION_REDUCE_DEFINES_SVH
`define FRACTION_REDUCE_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define FR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fraction_reduce check failed");

// next-cycle implication, disabled while in reset
`define FR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fraction_reduce check failed");

`endif

/* hw/rtl/fr_pkg.sv */
`default_nettype none
package fr_pkg;

  localparam int WIDTH_DEFAULT = 32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GCD,
    ST_DIVN,
    ST_DIVD,
    ST_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic gcd_step;
    logic div_start;
    logic div_sel;    // 0: numerator, 1: denominator
    logic store_qn;
    logic store_qd;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic dzero;
    logic gcd_done;
    logic div_done;
    logic out_busy;
  } sts_t;

endpackage
`default_nettype wire

/* hw/rtl/fr_div.sv */
`default_nettype none
module fr_div #(
  parameter int N = fr_pkg::WIDTH_DEFAULT - 1
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic [N-1:0] dividend,
  input  wire logic [N-1:0] divisor,
  output logic              done,
  output logic [N-1:0]      quotient
);

  localparam int CW = $clog2(N);

  logic [N-1:0]  rem;
  logic [N-1:0]  dsr;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [N:0]    shifted;
  logic [N:0]    diff;
  logic          ge;

  // restoring division, one quotient bit per cycle
  always_comb begin
    shifted = {rem, quotient[N-1]};
    diff    = shifted - {1'b0, dsr};
    ge      = !diff[N];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(N - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      quotient <= dividend;
      dsr      <= divisor;
    end else if (busy) begin
      rem      <= ge ? diff[N-1:0] : shifted[N-1:0];
      quotient <= {quotient[N-2:0], ge};
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/fr_dp.sv */
`default_nettype none
module fr_dp #(
  parameter int WIDTH = fr_pkg::WIDTH_DEFAULT
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire fr_pkg::cmd_t     cmd,
  output fr_pkg::sts_t          sts,
  input  wire logic [WIDTH-1:0] in_num,
  input  wire logic [WIDTH-1:0] in_den,
  input  wire logic             out_ready,
  output logic                  out_valid,
  output logic [WIDTH-1:0]      out_num,
  output logic [WIDTH-2:0]      out_den,
  output logic                  out_zero
);

  localparam int M = WIDTH - 1;

  logic [WIDTH-1:0] nabs, dabs;
  logic [M-1:0]     nmag_in, dmag_in;
  logic             nneg, dneg, dzero;
  logic [M-1:0]     a, b, nq, dq, qn, qd;
  logic [M-1:0]     g, diff, mag_out;
  logic             a_ge_b, neg_out;
  logic             div_done;
  logic [M-1:0]     quotient;
  logic [WIDTH-1:0] mag_ext;

  // magnitudes, most negative input saturates
  always_comb begin
    nabs    = in_num[WIDTH-1] ? (~in_num + 1'b1) : in_num;
    dabs    = in_den[WIDTH-1] ? (~in_den + 1'b1) : in_den;
    nmag_in = nabs[WIDTH-1] ? {M{1'b1}} : nabs[M-1:0];
    dmag_in = dabs[WIDTH-1] ? {M{1'b1}} : dabs[M-1:0];
  end

  always_comb begin
    a_ge_b = a >= b;
    diff   = a_ge_b ? (a - b) : (b - a);
    g      = (a == '0) ? b : a;
  end

  // binary gcd, the common power of two is stripped from nq and dq as it goes
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      nneg  <= in_num[WIDTH-1];
      dneg  <= in_den[WIDTH-1];
      dzero <= dmag_in == '0;
      a     <= nmag_in;
      b     <= dmag_in;
      nq    <= nmag_in;
      dq    <= dmag_in;
    end else if (cmd.gcd_step) begin
      if (!a[0] && !b[0]) begin
        a  <= a >> 1;
        b  <= b >> 1;
        nq <= nq >> 1;
        dq <= dq >> 1;
      end else if (!a[0]) begin
        a <= a >> 1;
      end else if (!b[0]) begin
        b <= b >> 1;
      end else if (a_ge_b) begin
        a <= diff >> 1;
      end else begin
        b <= diff >> 1;
      end
    end
    if (cmd.store_qn) qn <= quotient;
    if (cmd.store_qd) qd <= quotient;
  end

  fr_div #(.N(M)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (cmd.div_sel ? dq : nq),
    .divisor  (g),
    .done     (div_done),
    .quotient (quotient)
  );

  always_comb begin
    mag_out = dzero ? nq : qn;
    neg_out = dzero ? nneg : ((nneg != dneg) && (qn != '0));
    mag_ext = {1'b0, mag_out};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_num  <= neg_out ? (~mag_ext + 1'b1) : mag_ext;
      out_den  <= dzero ? '0 : qd;
      out_zero <= dzero;
    end
  end

  always_comb begin
    sts.dzero    = dzero;
    sts.gcd_done = (a == '0) || (b == '0);
    sts.div_done = div_done;
    sts.out_busy = out_valid && !out_ready;
  end

endmodule
`default_nettype wire

/* hw/rtl/fr_ctrl.sv */
`default_nettype none
module fr_ctrl (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire fr_pkg::sts_t sts,
  output fr_pkg::cmd_t      cmd
);

  fr_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      fr_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = fr_pkg::ST_GCD;
        end
      end
      fr_pkg::ST_GCD: begin
        if (sts.dzero) begin
          state_next = fr_pkg::ST_DONE;
        end else if (sts.gcd_done) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = 1'b0;
          state_next    = fr_pkg::ST_DIVN;
        end else begin
          cmd.gcd_step = 1'b1;
        end
      end
      fr_pkg::ST_DIVN: begin
        if (sts.div_done) begin
          cmd.store_qn  = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_sel   = 1'b1;
          state_next    = fr_pkg::ST_DIVD;
        end
      end
      fr_pkg::ST_DIVD: begin
        if (sts.div_done) begin
          cmd.store_qd = 1'b1;
          state_next   = fr_pkg::ST_DONE;
        end
      end
      fr_pkg::ST_DONE: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = fr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = fr_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

/* hw/rtl/fraction_reduce.sv */
// fraction_reduce: reduces numerator/denominator to lowest terms with a
// positive denominator.
// input stream s_axis: one transfer carries one fraction. s_axis_tready is
// high only while the block is free, so items are taken one at a time.
// output stream m_axis: one transfer per input item, in order. tuser flags a
// zero denominator; the numerator then passes through and the denominator is 0.
// from the s_axis transfer to m_axis_tvalid, the block runs the binary gcd
// (one subtract-or-shift per cycle), then two divisions on a shared
// restoring divider at WIDTH-1 quotient bits each; a zero denominator skips
// the gcd and both divisions. a new item is taken only once the last has
// left the gcd loop and the divider. the result sits in an output register,
// so the next item is accepted and worked on while a finished result waits
// for m_axis_tready.
// when the receiver stalls, m_axis holds its data; only when a second
// result is ready does the block wait and keep s_axis_tready low.
// reset (rst, synchronous) returns the controller to idle and drops
// m_axis_tvalid; no clearing pass is needed.
`default_nettype none
module fraction_reduce #(
  parameter int WIDTH = fr_pkg::WIDTH_DEFAULT
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // numerator, denominator
  input  wire logic [((2*WIDTH+7)/8)*8-1:0]        s_axis_tdata,
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // reduced_numerator, reduced_denominator, zero pad
  output logic [((2*WIDTH-1+7)/8)*8-1:0]           m_axis_tdata,
  // zero_denominator
  output logic                                     m_axis_tuser
);

  localparam int OUT_W = ((2 * WIDTH - 1 + 7) / 8) * 8;

  fr_pkg::cmd_t     cmd;
  fr_pkg::sts_t     sts;
  logic [WIDTH-1:0] out_num;
  logic [WIDTH-2:0] out_den;

  fr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  fr_dp #(.WIDTH(WIDTH)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_num    (s_axis_tdata[WIDTH-1:0]),
    .in_den    (s_axis_tdata[2*WIDTH-1:WIDTH]),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_num   (out_num),
    .out_den   (out_den),
    .out_zero  (m_axis_tuser)
  );

  assign m_axis_tdata = OUT_W'({out_den, out_num});

endmodule
`default_nettype wire

/* hw/rtl/fr_chk.sv */
`default_nettype none
`include "fraction_reduce_defines.svh"
module fr_chk #(
  parameter int WIDTH = fr_pkg::WIDTH_DEFAULT
) (
  input wire logic                                clk,
  input wire logic                                rst,
  input wire logic                                s_axis_tvalid,
  input wire logic                                s_axis_tready,
  input wire logic                                m_axis_tvalid,
  input wire logic                                m_axis_tready,
  input wire logic [((2*WIDTH-1+7)/8)*8-1:0]      m_axis_tdata,
  input wire logic                                m_axis_tuser
);

  // a stalled result holds
  `FR_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

  // one item in work at a time
  `FR_ASSERT_NEXT(a_one_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready)

  // a reduced denominator is never zero unless flagged
  `FR_ASSERT_NOW(a_den_nonzero, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[2*WIDTH-2:WIDTH] != '0)

  // flagged results carry a zero denominator
  `FR_ASSERT_NOW(a_den_zero_flag, m_axis_tvalid && m_axis_tuser, m_axis_tdata[2*WIDTH-2:WIDTH] == '0)

  // the numerator never reaches the most negative code
  `FR_ASSERT_NOW(a_num_range, m_axis_tvalid && m_axis_tdata[WIDTH-1], m_axis_tdata[WIDTH-2:0] != '0)

endmodule

bind fraction_reduce fr_chk #(.WIDTH(WIDTH)) u_fr_chk (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire
